// ===== rtl/core/srel_pkg.sv =====
// srel_pkg: shared types, register indexes and constants of the sample-rate expander
// used by every file under rtl/core; depends on nothing else
package srel_pkg;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP_RATIO   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OUTPUT_TOTAL = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ALPHA_Q16    = 2'd2;

    // field widths and reset values
    localparam int unsigned STEP_BITS  = 16;
    localparam int unsigned TOTAL_BITS = 24;
    localparam int unsigned ALPHA_BITS = 17;
    localparam int unsigned CFG_DATA_BITS = 24;
    localparam logic [STEP_BITS-1:0]  STEP_RESET  = 16'd256;
    localparam logic [TOTAL_BITS-1:0] TOTAL_RESET = 24'd0;
    localparam logic [ALPHA_BITS-1:0] ALPHA_UNITY = 17'h10000;

    // depth of the queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    // one source byte
    typedef struct packed {
        logic [7:0] sample_byte;
        logic       first;
    } t_in_item;

    // one output sample
    typedef struct packed {
        logic signed [15:0] pcm_sample;
        logic               last;
    } t_out_item;

    // oldest queued byte as seen by the back end
    typedef struct packed {
        logic     valid;
        t_in_item item;
    } t_queue_head;

    // live configuration
    typedef struct packed {
        logic [STEP_BITS-1:0]  step_ratio;
        logic [TOTAL_BITS-1:0] output_total;
        logic [ALPHA_BITS-1:0] alpha_q16;
    } t_cfg;

    // byte*257 - 32768 is the byte repeated with the top bit flipped
    function automatic logic signed [15:0] widen_sample(input logic [7:0] b);
        widen_sample = signed'({~b[7], b[6:0], b});
    endfunction

endpackage

// ===== rtl/core/srel_front.sv =====
// srel_front: accepts source bytes and holds them in a short queue for the back end
// depends on srel_pkg
module srel_front
    import srel_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_in_item    i_in_item,
    output t_queue_head o_head,
    input  logic        i_head_pop
);

    localparam int unsigned PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    t_in_item              r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   r_wr_ptr;
    logic [PTR_BITS-1:0]   r_rd_ptr;
    logic [PTR_BITS:0]     r_count;
    logic                  wr_en;
    logic                  rd_en;

    // handshake decode
    assign full  = (r_count == (PTR_BITS+1)'(QUEUE_DEPTH));
    assign wr_en = push && !full;
    assign rd_en = i_head_pop && (r_count != '0);

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_in_item;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/srel_back.sv =====
// srel_back: steps through the outputs of each queued byte, filters them, holds the result
// depends on srel_pkg
module srel_back
    import srel_pkg::*;
#(
    parameter int unsigned MAX_OUT_PER_IN = 8,
    parameter int unsigned COUNT_BITS     = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_queue_head i_head,
    output logic        o_head_pop,
    output logic        empty,
    input  logic        pop,
    output t_out_item   o_out_item
);

    localparam int unsigned CW = $clog2(MAX_OUT_PER_IN + 1);
    localparam int unsigned TW = (COUNT_BITS > TOTAL_BITS) ? COUNT_BITS : TOTAL_BITS;
    localparam int unsigned SRC_BITS = COUNT_BITS + 8;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SRC,
        S_TEST,
        S_SUM
    } t_state;

    t_state                    r_state;
    logic [COUNT_BITS-1:0]     r_out_idx;
    logic [COUNT_BITS-1:0]     r_in_idx;
    logic [CW-1:0]             r_emit_cnt;
    logic signed [15:0]        r_prev;
    logic signed [15:0]        r_x;
    logic [SRC_BITS-1:0]       r_src;
    logic signed [34:0]        r_prod;
    logic                      r_out_valid;
    t_out_item                 r_out_item;

    logic [TW-1:0]             total_wide;
    logic [TW-1:0]             cnt_max_wide;
    logic [COUNT_BITS-1:0]     total_eff;
    logic [COUNT_BITS+15:0]    src_prod;
    logic                      go;
    logic [ALPHA_BITS-1:0]     a_eff;
    logic signed [17:0]        a_s;
    logic signed [16:0]        diff;
    logic signed [34:0]        sum;
    logic signed [18:0]        quot;
    logic signed [15:0]        y;
    logic                      is_last;
    logic                      out_free;
    logic                      emit;

    // total limited to what the counter holds
    assign total_wide   = TW'(i_cfg.output_total);
    assign cnt_max_wide = TW'({COUNT_BITS{1'b1}});
    assign total_eff    = (total_wide > cnt_max_wide) ? COUNT_BITS'(cnt_max_wide)
                                                      : COUNT_BITS'(total_wide);

    // source position of the next output
    assign src_prod = (COUNT_BITS+16)'(r_out_idx) * (COUNT_BITS+16)'(i_cfg.step_ratio);

    // whether the next output belongs to this byte
    assign go = (r_emit_cnt < CW'(MAX_OUT_PER_IN)) && (r_out_idx < total_eff)
             && (r_src <= SRC_BITS'(r_in_idx));

    // filter: prev + a*(x-prev), truncated toward zero
    assign a_eff = i_cfg.alpha_q16[ALPHA_BITS-1] ? ALPHA_UNITY : i_cfg.alpha_q16;
    assign a_s   = signed'({1'b0, a_eff});
    assign diff  = 17'(r_x) - 17'(r_prev);
    assign sum   = r_prod + (35'(r_prev) <<< 16);

    always_comb begin
        quot = sum[34:16];
        if (sum[34] && (sum[15:0] != '0)) begin
            quot = quot + 19'sd1;
        end
        y = (r_out_idx == '0) ? r_x : quot[15:0];
    end

    assign is_last  = ((COUNT_BITS+1)'(r_out_idx) + 1'b1) == (COUNT_BITS+1)'(total_eff);
    assign out_free = !r_out_valid || pop;
    assign emit     = (r_state == S_SUM) && out_free;

    assign o_head_pop = (r_state == S_IDLE) && i_head.valid;
    assign empty      = !r_out_valid;
    assign o_out_item = r_out_item;

    // sequencer, filter state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_idx   <= '0;
            r_in_idx    <= '0;
            r_emit_cnt  <= '0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // output register holds a sample until it is popped
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_head.valid) begin
                        r_x        <= widen_sample(i_head.item.sample_byte);
                        r_emit_cnt <= '0;
                        if (i_head.item.first) begin
                            r_out_idx <= '0;
                            r_in_idx  <= '0;
                        end
                        r_state <= S_SRC;
                    end
                end
                S_SRC: begin
                    r_src   <= src_prod[COUNT_BITS+15:8];
                    r_state <= S_TEST;
                end
                S_TEST: begin
                    if (go) begin
                        r_prod  <= 35'(a_s) * 35'(diff);
                        r_state <= S_SUM;
                    end else begin
                        if (r_in_idx != {COUNT_BITS{1'b1}}) begin
                            r_in_idx <= r_in_idx + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_SUM: begin
                    if (out_free) begin
                        r_out_item.pcm_sample <= y;
                        r_out_item.last       <= is_last;
                        r_prev                <= y;
                        r_out_idx             <= r_out_idx + 1'b1;
                        r_emit_cnt            <= r_emit_cnt + 1'b1;
                        r_state               <= S_SRC;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/sample_rate_expand_lowpass.sv =====
// sample_rate_expand_lowpass: top level, configuration registers, front queue and back end
// depends on srel_pkg, srel_front and srel_back
//
// Usage: source bytes enter through push/full with i_in_item (sample_byte, first);
// a transaction happens when push is high and full is low. Set first on the opening
// byte of a sound. Output samples leave through empty/pop on o_out_item
// (pcm_sample, last); the sample on the ports is taken when pop is high and empty low.
// Registers step_ratio, output_total and alpha_q16 are written over the cfg channel
// (index, data; ready always high); the user must write them only while no byte is
// in flight; the block itself does not enforce this. Sequence: a byte waits in a
// two-entry queue; the back end takes it in its idle state, then for each output
// runs the source position multiply, the compare and filter multiply, and the sum
// and write, and ends with a final position and compare step. The first output is
// written in the first sum step, after its position and compare steps. Throughput
// is set by the back end sequencer and the filter feedback through the previous
// sample. If pop stays low, the back end halts with its next sample ready and the
// queue fills, raising full. Reset clears counters, previous sample, queue and
// output register, and loads the register defaults.
module sample_rate_expand_lowpass
    import srel_pkg::*;
#(
    parameter int unsigned MAX_OUT_PER_IN = 8,
    parameter int unsigned COUNT_BITS     = 24
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  t_in_item                  i_in_item,
    output logic                      empty,
    input  logic                      pop,
    output t_out_item                 o_out_item,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    t_cfg        r_cfg;
    t_queue_head head;
    logic        head_pop;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_ratio   <= STEP_RESET;
            r_cfg.output_total <= TOTAL_RESET;
            r_cfg.alpha_q16    <= ALPHA_UNITY;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_STEP_RATIO:   r_cfg.step_ratio   <= i_cfg_data[STEP_BITS-1:0];
                CFG_OUTPUT_TOTAL: r_cfg.output_total <= i_cfg_data[TOTAL_BITS-1:0];
                CFG_ALPHA_Q16:    r_cfg.alpha_q16    <= i_cfg_data[ALPHA_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // byte queue
    srel_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (i_in_item),
        .o_head     (head),
        .i_head_pop (head_pop)
    );

    // output sequencer and filter
    srel_back #(
        .MAX_OUT_PER_IN (MAX_OUT_PER_IN),
        .COUNT_BITS     (COUNT_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_head     (head),
        .o_head_pop (head_pop),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item)
    );

endmodule

// ===== test/tb_sample_rate_expand_lowpass.sv =====
// tb_sample_rate_expand_lowpass: self-checking bench for the sample-rate expander
// holds a scoreboard class that predicts every output sample; depends on srel_pkg
// and the sample_rate_expand_lowpass top level
module tb_sample_rate_expand_lowpass;
    import srel_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_OUT_PER_IN = 8;
    localparam int unsigned COUNT_BITS     = 24;
    localparam int unsigned DRAIN_CYCLES   = 40;
    localparam int unsigned CYCLE_LIMIT    = 1000000;
    localparam int unsigned RANDOM_BYTES   = 350;
    localparam int unsigned MAX_REPORTS    = 100;

    // predicts output samples from accepted bytes and checks what comes out
    class resample_scoreboard;
        logic [STEP_BITS-1:0]   step_ratio   = STEP_RESET;
        logic [TOTAL_BITS-1:0]  output_total = TOTAL_RESET;
        logic [ALPHA_BITS-1:0]  alpha        = ALPHA_UNITY;
        longint unsigned        out_pos      = 0;
        longint unsigned        src_pos      = 0;
        logic signed [15:0]     prev_sample  = '0;
        t_out_item              expected_q[$];
        int unsigned            errors       = 0;

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_STEP_RATIO:   step_ratio   = data[STEP_BITS-1:0];
                CFG_OUTPUT_TOTAL: output_total = data[TOTAL_BITS-1:0];
                CFG_ALPHA_Q16:    alpha        = data[ALPHA_BITS-1:0];
                default: ;
            endcase
        endfunction

        // expected samples caused by one source byte
        function void take_byte(t_in_item item);
            longint signed   x;
            longint signed   a;
            longint signed   acc;
            longint unsigned src;
            int              count;
            bit              more;
            logic signed [15:0] y;
            t_out_item       sample;
            x = longint'(item.sample_byte) * 257 - 32768;
            a = (alpha > ALPHA_UNITY) ? 65536 : longint'(alpha);
            if (item.first) begin
                out_pos = 0;
                src_pos = 0;
            end
            count = 0;
            more  = 1'b1;
            while (more && count < MAX_OUT_PER_IN && out_pos < output_total) begin
                src = (out_pos * step_ratio) >> 8;
                if (src > src_pos) begin
                    more = 1'b0;
                end else begin
                    // opening sample of a sound skips the filter
                    if (out_pos == 0) begin
                        y = x[15:0];
                    end else begin
                        acc = a * x + (65536 - a) * longint'(prev_sample);
                        y = 16'(acc / 65536);
                    end
                    prev_sample       = y;
                    sample.pcm_sample = y;
                    sample.last       = (out_pos + 1 == output_total);
                    expected_q.push_back(sample);
                    out_pos++;
                    count++;
                end
            end
            // source position saturates at the counter limit
            if (src_pos < (64'd1 << COUNT_BITS) - 1) src_pos++;
        endfunction

        function void note_error();
            errors++;
            if (errors == MAX_REPORTS) $display("%0t: further mismatches counted only", $time);
        endfunction

        function void check_sample(t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                if (errors < MAX_REPORTS)
                    $display("%0t: sample with none expected, actual pcm_sample=%0d last=%0b",
                             $time, $signed(got.pcm_sample), got.last);
                note_error();
                return;
            end
            want = expected_q.pop_front();
            if (got.pcm_sample !== want.pcm_sample) begin
                if (errors < MAX_REPORTS)
                    $display("%0t: pcm_sample expected %0d actual %0d", $time,
                             $signed(want.pcm_sample), $signed(got.pcm_sample));
                note_error();
            end
            if (got.last !== want.last) begin
                if (errors < MAX_REPORTS)
                    $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
                note_error();
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      push;
    logic                      full;
    t_in_item                  in_item;
    logic                      empty;
    logic                      pop;
    t_out_item                 out_item;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    resample_scoreboard sb = new();
    int unsigned tx_idle_pct = 33;
    int unsigned rx_idle_pct = 78;
    int unsigned cycle_count = 0;
    int unsigned random_sent = 0;

    sample_rate_expand_lowpass #(
        .MAX_OUT_PER_IN(MAX_OUT_PER_IN),
        .COUNT_BITS    (COUNT_BITS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (out_item),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side: check each popped sample, then decide on stalling
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) sb.check_sample(out_item);
            pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // one byte transaction, with random gaps in front
    task automatic send_byte(input logic [7:0] value, input logic first);
        t_in_item item;
        item.sample_byte = value;
        item.first       = first;
        while ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push    <= 1'b1;
        in_item <= item;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.take_byte(item);
    endtask

    // stop sending, wait for every expected sample, then let silent bytes finish
    task automatic wait_idle();
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    // all three registers, only while nothing is in flight
    task automatic configure(input int unsigned step, input int unsigned total,
                             input int unsigned alpha_val);
        wait_idle();
        write_reg(CFG_STEP_RATIO, CFG_DATA_BITS'(step));
        write_reg(CFG_OUTPUT_TOTAL, CFG_DATA_BITS'(total));
        write_reg(CFG_ALPHA_Q16, CFG_DATA_BITS'(alpha_val));
        cfg_valid <= 1'b0;
    endtask

    // one sound with random content and an occasional restart inside it
    task automatic random_sound();
        longint unsigned need;
        int unsigned     nbytes;
        bit              start;
        if ($urandom_range(1) == 0 || random_sent == 0) begin
            int unsigned step;
            int unsigned total;
            int unsigned alpha_val;
            case ($urandom_range(9))
                0:       step = ($urandom_range(1) != 0) ? $urandom_range(0, 1)
                                                         : $urandom_range(31, 32);
                1:       step = ($urandom_range(1) != 0) ? 65535 : $urandom_range(0, 65535);
                default: step = $urandom_range(32, 1024);
            endcase
            case ($urandom_range(9))
                0:       total = 0;
                1:       total = 16777215;
                2:       total = $urandom_range(0, 16777215);
                default: total = $urandom_range(1, 48);
            endcase
            case ($urandom_range(7))
                0:       alpha_val = 0;
                1:       alpha_val = 65536;
                2:       alpha_val = $urandom_range(65537, 131071);
                default: alpha_val = $urandom_range(0, 65536);
            endcase
            configure(step, total, alpha_val);
        end
        if (sb.output_total == 0) need = 1;
        else need = (((longint'(sb.output_total) - 1) * sb.step_ratio) >> 8) + 1;
        nbytes = (need > 40) ? 40 : int'(need);
        nbytes = nbytes + $urandom_range(0, 3);
        // a few sounds run on from the previous one without a first flag
        start = ($urandom_range(9) != 0);
        for (int unsigned k = 0; k < nbytes; k++) begin
            send_byte(8'($urandom_range(0, 255)),
                      (k == 0 && start) || ($urandom_range(49) == 0));
            random_sent++;
        end
    endtask

    initial begin
        push      <= 1'b0;
        in_item   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_STEP_RATIO;
        cfg_data  <= '0;
        i_rst_n   <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // bytes before any sound: reset total is zero, so nothing comes out
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        // counters carried from reset, then a byte past the end of the sound
        configure(256, 6, 65536);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h01, 1'b0);
        // zero step with alpha above unity: every output reads the current byte
        configure(0, 20, 131071);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h55, 1'b0);
        // largest step, single-sample sound
        configure(65535, 1, 0);
        send_byte(8'hAA, 1'b1);
        send_byte(8'h33, 1'b0);
        // full counter range as total, alpha zero holds the first sample
        configure(32, 16777215, 0);
        send_byte(8'h10, 1'b1);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h81, 1'b0);
        // step too small for one byte: leftovers spill onto later bytes, restart inside
        configure(31, 40, 65535);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h40, 1'b1);
        send_byte(8'h7F, 1'b0);

        // random sounds in three idling phases
        while (random_sent < RANDOM_BYTES) begin
            if (random_sent < RANDOM_BYTES / 3) begin
                tx_idle_pct = 33;
                rx_idle_pct = 78;
            end else if (random_sent < 2 * RANDOM_BYTES / 3) begin
                tx_idle_pct = 78;
                rx_idle_pct = 33;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            random_sound();
        end

        wait_idle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
